// ===== design/rob8_pkg.sv =====
// Package for the 8bpp raster-op blitter: field widths, configuration register
// indexes, logic-op codes, shared structs and the byte combine function.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps

package rob8_pkg;

  localparam int unsigned PixW     = 8;
  localparam int unsigned OutAddrW = 24;
  localparam int unsigned BaseW    = 24;
  localparam int unsigned StrideW  = 15;
  localparam int unsigned CountW   = 13;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned QDepth   = 2;

  typedef logic [PixW-1:0]     pixel_t;
  typedef logic [OutAddrW-1:0] out_addr_t;
  typedef logic [BaseW-1:0]    base_t;
  typedef logic [StrideW-1:0]  stride_t;
  typedef logic [CountW-1:0]   count_t;

  // Configuration register indexes; the remaining codes of the index port are ignored.
  typedef enum logic [CfgIdxW-1:0] {
    CfgLogicOp    = 4'd0,
    CfgSrcBase    = 4'd1,
    CfgSrcStride  = 4'd2,
    CfgDstBase    = 4'd3,
    CfgDstStride  = 4'd4,
    CfgRectWidth  = 4'd5,
    CfgRectHeight = 4'd6,
    CfgReverse    = 4'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OpZero      = 4'd0,
    OpAnd       = 4'd1,
    OpSrcAndNd  = 4'd2,
    OpSrc       = 4'd3,
    OpNsAndDst  = 4'd4,
    OpDst       = 4'd5,
    OpXor       = 4'd6,
    OpOr        = 4'd7,
    OpNor       = 4'd8,
    OpXnor      = 4'd9,
    OpNotDst    = 4'd10,
    OpSrcOrNd   = 4'd11,
    OpNotSrc    = 4'd12,
    OpNsOrDst   = 4'd13,
    OpNand      = 4'd14,
    OpOnes      = 4'd15
  } logic_op_e;

  // Geometry registers that drive the address walker.
  typedef struct packed {
    base_t   src_base;
    stride_t src_stride;
    base_t   dst_base;
    stride_t dst_stride;
    count_t  rect_width;
    count_t  rect_height;
    logic    reverse;
  } geom_t;

  // One classified item as it waits between the walker and the combine stage.
  typedef struct packed {
    out_addr_t src_addr;
    out_addr_t write_addr;
    logic      last;
    pixel_t    src_pixel;
    pixel_t    dst_pixel;
  } entry_t;

  localparam count_t CountOne = count_t'(1);

  // A count of zero behaves as one.
  function automatic count_t count_of(count_t v);
    return (v == '0) ? CountOne : v;
  endfunction

  function automatic pixel_t combine(logic_op_e op, pixel_t s, pixel_t d);
    pixel_t r;
    unique case (op)
      OpZero:     r = '0;
      OpAnd:      r = s & d;
      OpSrcAndNd: r = s & ~d;
      OpSrc:      r = s;
      OpNsAndDst: r = ~s & d;
      OpDst:      r = d;
      OpXor:      r = s ^ d;
      OpOr:       r = s | d;
      OpNor:      r = ~(s | d);
      OpXnor:     r = ~(s ^ d);
      OpNotDst:   r = ~d;
      OpSrcOrNd:  r = s | ~d;
      OpNotSrc:   r = ~s;
      OpNsOrDst:  r = ~s | d;
      OpNand:     r = ~(s & d);
      OpOnes:     r = '1;
      default:    r = '1;
    endcase
    return r;
  endfunction

endpackage

// ===== design/rob8_front.sv =====
// Front end of the blitter: accepts items and walks the rectangle, tagging each
// item with its source and destination addresses and the last-pixel flag.
// Depends on rob8_pkg.
`timescale 1ns / 1ps

module rob8_front #(
  parameter int unsigned ADDR_BITS = 24
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rob8_pkg::geom_t           geom_i,
  input  rob8_pkg::geom_t           geom_next_i,
  input  logic                      cfg_hit_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  rob8_pkg::pixel_t          src_pixel_i,
  input  rob8_pkg::pixel_t          dst_pixel_i,
  input  logic                      full_i,
  output logic                      push_o,
  output rob8_pkg::entry_t          entry_o
);

  typedef logic [ADDR_BITS-1:0] addr_t;

  rob8_pkg::count_t col_q, col_d, rows_q, rows_d;
  addr_t src_row_q, src_row_d, dst_row_q, dst_row_d;
  addr_t src_cur_q, src_cur_d, dst_cur_q, dst_cur_d;

  rob8_pkg::geom_t rl;
  logic  step;
  addr_t src_next, dst_next, src_row_next, dst_row_next;
  addr_t src_stride_ext, dst_stride_ext;

  assign in_ready_o = !full_i;
  assign step       = in_valid_i && !full_i;
  assign push_o     = step;

  assign entry_o.src_addr   = rob8_pkg::out_addr_t'(src_cur_q);
  assign entry_o.write_addr = rob8_pkg::out_addr_t'(dst_cur_q);
  assign entry_o.last       = (col_q <= rob8_pkg::CountOne) && (rows_q <= rob8_pkg::CountOne);
  assign entry_o.src_pixel  = src_pixel_i;
  assign entry_o.dst_pixel  = dst_pixel_i;

  // A register write reloads from the values being written this cycle.
  assign rl = cfg_hit_i ? geom_next_i : geom_i;

  assign src_stride_ext = addr_t'(geom_i.src_stride);
  assign dst_stride_ext = addr_t'(geom_i.dst_stride);

  assign src_next     = geom_i.reverse ? src_cur_q - addr_t'(1) : src_cur_q + addr_t'(1);
  assign dst_next     = geom_i.reverse ? dst_cur_q - addr_t'(1) : dst_cur_q + addr_t'(1);
  assign src_row_next = geom_i.reverse ? src_row_q - src_stride_ext : src_row_q + src_stride_ext;
  assign dst_row_next = geom_i.reverse ? dst_row_q - dst_stride_ext : dst_row_q + dst_stride_ext;

  always_comb begin
    col_d     = col_q;
    rows_d    = rows_q;
    src_row_d = src_row_q;
    dst_row_d = dst_row_q;
    src_cur_d = src_cur_q;
    dst_cur_d = dst_cur_q;
    priority if (cfg_hit_i || (step && col_q <= rob8_pkg::CountOne
                                    && rows_q <= rob8_pkg::CountOne)) begin
      col_d     = rob8_pkg::count_of(rl.rect_width);
      rows_d    = rob8_pkg::count_of(rl.rect_height);
      src_row_d = addr_t'(rl.src_base);
      dst_row_d = addr_t'(rl.dst_base);
      src_cur_d = addr_t'(rl.src_base);
      dst_cur_d = addr_t'(rl.dst_base);
    end else if (step && col_q > rob8_pkg::CountOne) begin
      col_d     = col_q - rob8_pkg::CountOne;
      src_cur_d = src_next;
      dst_cur_d = dst_next;
    end else if (step) begin
      rows_d    = rows_q - rob8_pkg::CountOne;
      col_d     = rob8_pkg::count_of(geom_i.rect_width);
      src_row_d = src_row_next;
      dst_row_d = dst_row_next;
      src_cur_d = src_row_next;
      dst_cur_d = dst_row_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= rob8_pkg::CountOne;
      rows_q    <= rob8_pkg::CountOne;
      src_row_q <= '0;
      dst_row_q <= '0;
      src_cur_q <= '0;
      dst_cur_q <= '0;
    end else begin
      col_q     <= col_d;
      rows_q    <= rows_d;
      src_row_q <= src_row_d;
      dst_row_q <= dst_row_d;
      src_cur_q <= src_cur_d;
      dst_cur_q <= dst_cur_d;
    end
  end

endmodule

// ===== design/rob8_queue.sv =====
// Short queue between the address walker and the combine stage.
// Depends on rob8_pkg for the entry type and depth.
`timescale 1ns / 1ps

module rob8_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rob8_pkg::entry_t  entry_i,
  output logic              full_o,
  output logic              deq_valid_o,
  input  logic              deq_ready_i,
  output rob8_pkg::entry_t  entry_o
);

  localparam int unsigned PtrW = $clog2(rob8_pkg::QDepth);
  localparam int unsigned CntW = $clog2(rob8_pkg::QDepth + 1);

  rob8_pkg::entry_t mem_q [rob8_pkg::QDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q, count_d;
  logic             pop;

  assign full_o      = (count_q == CntW'(rob8_pkg::QDepth));
  assign deq_valid_o = (count_q != '0);
  assign pop         = deq_ready_i && deq_valid_o;
  assign entry_o     = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(rob8_pkg::QDepth))
    else $error("queue count beyond depth");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    PtrW'(wr_ptr_q - rd_ptr_q) == count_q[PtrW-1:0])
    else $error("queue pointers disagree with count");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop) |=> count_q == $past(count_q) + CntW'(1))
    else $error("queue count did not grow on push");

endmodule

// ===== design/rob8_back.sv =====
// Back end of the blitter: applies the logic operation to a queued item and
// holds the result in the output register. Depends on rob8_pkg.
`timescale 1ns / 1ps

module rob8_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rob8_pkg::logic_op_e  logic_op_i,
  input  logic                 deq_valid_i,
  output logic                 deq_ready_o,
  input  rob8_pkg::entry_t     entry_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rob8_pkg::out_addr_t  src_addr_o,
  output rob8_pkg::out_addr_t  write_addr_o,
  output rob8_pkg::pixel_t     result_pixel_o,
  output logic                 last_o
);

  logic                valid_q;
  logic                load;
  rob8_pkg::out_addr_t src_addr_q, write_addr_q;
  rob8_pkg::pixel_t    result_q;
  logic                last_q;

  assign deq_ready_o = !valid_q || out_ready_i;
  assign load        = deq_valid_i && deq_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (deq_ready_o) begin
      valid_q <= deq_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      src_addr_q   <= entry_i.src_addr;
      write_addr_q <= entry_i.write_addr;
      result_q     <= rob8_pkg::combine(logic_op_i, entry_i.src_pixel, entry_i.dst_pixel);
      last_q       <= entry_i.last;
    end
  end

  assign out_valid_o    = valid_q;
  assign src_addr_o     = src_addr_q;
  assign write_addr_o   = write_addr_q;
  assign result_pixel_o = result_q;
  assign last_o         = last_q;

endmodule

// ===== design/raster_op_blit_8bpp_core.sv =====
// Top level of the 8bpp raster-op blitter: configuration registers, address
// walker, item queue and combine stage. Depends on rob8_pkg and the rob8_* modules.
`timescale 1ns / 1ps

// The blitter walks a rectangle of rect_width by rect_height byte pixels and
// takes one item per pixel: the source byte and the current destination byte at
// that position. For each item it returns the source address, the address to
// write, the byte produced by the selected logic operation and a flag on the
// final pixel. In the forward direction pixels ascend within a row and rows
// advance by their stride; with reverse set both descend from the base
// addresses. Addresses wrap at ADDR_BITS bits and are reported on 24-bit ports.
// A width or height of zero counts as one. Any write to a register in the list
// (indexes 0 to 7) returns the walk to the first pixel; other indexes are ignored.
// After the last pixel the walk starts over on its own. Registers should only be
// written while no item is in flight. The block takes one item every cycle while
// the queue is not full: the address walker updates its counters and cursors as
// each item is accepted, and a two-entry queue plus the output register let the
// input keep flowing while a result waits. An accepted item enters the queue, and
// the combine stage registers it into the output register once that register is
// free or its result is being taken.

module raster_op_blit_8bpp_core #(
  parameter int unsigned ADDR_BITS = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rob8_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [rob8_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [rob8_pkg::PixW-1:0]          src_pixel_i,
  input  logic [rob8_pkg::PixW-1:0]          dst_pixel_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [rob8_pkg::OutAddrW-1:0]      src_addr_o,
  output logic [rob8_pkg::OutAddrW-1:0]      write_addr_o,
  output logic [rob8_pkg::PixW-1:0]          result_pixel_o,
  output logic                               last_o
);

  rob8_pkg::logic_op_e op_q, op_d;
  rob8_pkg::geom_t     geom_q, geom_d;
  logic                cfg_hit;

  logic              push, full, deq_valid, deq_ready;
  rob8_pkg::entry_t  front_entry, queue_entry;

  // Register file. Writes land at once; cfg_hit tells the walker to restart
  // from the values being written.
  always_comb begin
    op_d    = op_q;
    geom_d  = geom_q;
    cfg_hit = 1'b0;
    if (cfg_we_i) begin
      unique case (rob8_pkg::cfg_idx_e'(cfg_index_i))
        rob8_pkg::CfgLogicOp: begin
          op_d    = rob8_pkg::logic_op_e'(cfg_wdata_i[3:0]);
          cfg_hit = 1'b1;
        end
        rob8_pkg::CfgSrcBase: begin
          geom_d.src_base = cfg_wdata_i[rob8_pkg::BaseW-1:0];
          cfg_hit         = 1'b1;
        end
        rob8_pkg::CfgSrcStride: begin
          geom_d.src_stride = cfg_wdata_i[rob8_pkg::StrideW-1:0];
          cfg_hit           = 1'b1;
        end
        rob8_pkg::CfgDstBase: begin
          geom_d.dst_base = cfg_wdata_i[rob8_pkg::BaseW-1:0];
          cfg_hit         = 1'b1;
        end
        rob8_pkg::CfgDstStride: begin
          geom_d.dst_stride = cfg_wdata_i[rob8_pkg::StrideW-1:0];
          cfg_hit           = 1'b1;
        end
        rob8_pkg::CfgRectWidth: begin
          geom_d.rect_width = cfg_wdata_i[rob8_pkg::CountW-1:0];
          cfg_hit           = 1'b1;
        end
        rob8_pkg::CfgRectHeight: begin
          geom_d.rect_height = cfg_wdata_i[rob8_pkg::CountW-1:0];
          cfg_hit            = 1'b1;
        end
        rob8_pkg::CfgReverse: begin
          geom_d.reverse = cfg_wdata_i[0];
          cfg_hit        = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q               <= rob8_pkg::OpSrc;
      geom_q.src_base    <= '0;
      geom_q.src_stride  <= '0;
      geom_q.dst_base    <= '0;
      geom_q.dst_stride  <= '0;
      geom_q.rect_width  <= rob8_pkg::CountOne;
      geom_q.rect_height <= rob8_pkg::CountOne;
      geom_q.reverse     <= 1'b0;
    end else begin
      op_q   <= op_d;
      geom_q <= geom_d;
    end
  end

  rob8_front #(
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .geom_i      (geom_q),
    .geom_next_i (geom_d),
    .cfg_hit_i   (cfg_hit),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .src_pixel_i (src_pixel_i),
    .dst_pixel_i (dst_pixel_i),
    .full_i      (full),
    .push_o      (push),
    .entry_o     (front_entry)
  );

  rob8_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .entry_i     (front_entry),
    .full_o      (full),
    .deq_valid_o (deq_valid),
    .deq_ready_i (deq_ready),
    .entry_o     (queue_entry)
  );

  rob8_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .logic_op_i     (op_q),
    .deq_valid_i    (deq_valid),
    .deq_ready_o    (deq_ready),
    .entry_i        (queue_entry),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .src_addr_o     (src_addr_o),
    .write_addr_o   (write_addr_o),
    .result_pixel_o (result_pixel_o),
    .last_o         (last_o)
  );

endmodule

// ===== sim/tb_raster_op_blit_8bpp_core.sv =====
// Self-checking testbench for raster_op_blit_8bpp_core: directed and random blits checked
// against a cycle-free predictor of the address walk and the byte logic operation.
// Depends on rob8_pkg and the blitter RTL; needs no files or arguments.
`timescale 1ns / 1ps

module tb_raster_op_blit_8bpp_core;

  localparam int unsigned AddrBits       = 24;
  localparam int unsigned ClkPeriod      = 8;
  localparam int unsigned ResetCycles    = 12;
  // Extra idle time after the last expected result before a drain is called done.
  localparam int unsigned TailCycles     = 4;
  localparam int unsigned StallCycles    = 150;
  localparam int unsigned WatchdogCycles = 2000;
  localparam int unsigned RandomItems    = 330;
  localparam int unsigned IdlePercent    = 27;
  localparam int unsigned MaxReports     = 100;

  typedef logic [rob8_pkg::CfgIdxW-1:0]  cfg_idx_t;
  typedef logic [rob8_pkg::CfgDataW-1:0] cfg_data_t;
  typedef logic [AddrBits-1:0]           walk_addr_t;

  // Register indexes past the end of the list; the block must ignore writes to them.
  localparam cfg_idx_t IdxUnusedLo = 4'd8;
  localparam cfg_idx_t IdxUnusedHi = 4'd15;

  // One pixel write as the block should report it.
  typedef struct packed {
    rob8_pkg::out_addr_t src_addr;
    rob8_pkg::out_addr_t write_addr;
    rob8_pkg::pixel_t    pixel;
    logic                last;
  } pixel_write_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and the block's inputs, all known from time zero.
  // ---------------------------------------------------------------------------
  logic                                clk_i          = 1'b0;
  logic                                rst_ni         = 1'b0;
  logic                                cfg_we_i       = 1'b0;
  cfg_idx_t                            cfg_index_i    = '0;
  cfg_data_t                           cfg_wdata_i    = '0;
  logic                                in_valid_i     = 1'b0;
  logic                                in_ready_o;
  logic [rob8_pkg::PixW-1:0]           src_pixel_i    = '0;
  logic [rob8_pkg::PixW-1:0]           dst_pixel_i    = '0;
  logic                                out_valid_o;
  logic                                out_ready_i    = 1'b0;
  logic [rob8_pkg::OutAddrW-1:0]       src_addr_o;
  logic [rob8_pkg::OutAddrW-1:0]       write_addr_o;
  logic [rob8_pkg::PixW-1:0]           result_pixel_o;
  logic                                last_o;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  raster_op_blit_8bpp_core #(
    .ADDR_BITS(AddrBits)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .src_pixel_i   (src_pixel_i),
    .dst_pixel_i   (dst_pixel_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .src_addr_o    (src_addr_o),
    .write_addr_o  (write_addr_o),
    .result_pixel_o(result_pixel_o),
    .last_o        (last_o)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the registers and of the walk position.
  // ---------------------------------------------------------------------------
  rob8_pkg::logic_op_e reg_op;
  rob8_pkg::base_t     reg_src_base;
  rob8_pkg::stride_t   reg_src_stride;
  rob8_pkg::base_t     reg_dst_base;
  rob8_pkg::stride_t   reg_dst_stride;
  rob8_pkg::count_t    reg_width;
  rob8_pkg::count_t    reg_height;
  logic                reg_reverse;

  rob8_pkg::count_t    cols_to_go;
  rob8_pkg::count_t    rows_to_go;
  walk_addr_t          src_line;
  walk_addr_t          dst_line;
  walk_addr_t          src_pos;
  walk_addr_t          dst_pos;

  pixel_write_t expected_writes[$];
  int unsigned  mismatches  = 0;
  int unsigned  quiet_cycles = 0;

  // Stimulus controls. The sender's flag belongs to the test process alone; the
  // receiver's controls are updated with nonblocking writes and read at the edge.
  bit   feed_steady  = 1'b0;
  logic sink_steady  = 1'b0;
  int   stall_token  = 0;
  int   stall_seen   = 0;
  int   stall_left   = 0;

  // A programmed count of zero walks like a count of one.
  function automatic rob8_pkg::count_t at_least_one(rob8_pkg::count_t v);
    return (v == '0) ? rob8_pkg::count_t'(1) : v;
  endfunction

  // The op code doubles as a truth table: bit {~s, ~d} of the code is the output
  // for that pair of input bits, so s=1,d=1 selects bit 0 and s=0,d=0 bit 3.
  function automatic rob8_pkg::pixel_t rop_byte(rob8_pkg::logic_op_e op,
                                                rob8_pkg::pixel_t s, rob8_pkg::pixel_t d);
    logic [3:0]       truth;
    rob8_pkg::pixel_t r;
    truth = op;
    for (int i = 0; i < rob8_pkg::PixW; i++) begin
      r[i] = truth[{~s[i], ~d[i]}];
    end
    return r;
  endfunction

  // Back to the first pixel of the rectangle.
  function automatic void rewind_walk();
    cols_to_go = at_least_one(reg_width);
    rows_to_go = at_least_one(reg_height);
    src_line   = walk_addr_t'(reg_src_base);
    dst_line   = walk_addr_t'(reg_dst_base);
    src_pos    = src_line;
    dst_pos    = dst_line;
  endfunction

  function automatic void reset_model();
    reg_op         = rob8_pkg::OpSrc;
    reg_src_base   = '0;
    reg_src_stride = '0;
    reg_dst_base   = '0;
    reg_dst_stride = '0;
    reg_width      = rob8_pkg::count_t'(1);
    reg_height     = rob8_pkg::count_t'(1);
    reg_reverse    = 1'b0;
    rewind_walk();
  endfunction

  // Any write to a listed register restarts the walk; other indexes change nothing.
  function automatic void apply_cfg(cfg_idx_t idx, cfg_data_t data);
    case (idx)
      rob8_pkg::CfgLogicOp:    reg_op         = rob8_pkg::logic_op_e'(data[3:0]);
      rob8_pkg::CfgSrcBase:    reg_src_base   = data[rob8_pkg::BaseW-1:0];
      rob8_pkg::CfgSrcStride:  reg_src_stride = data[rob8_pkg::StrideW-1:0];
      rob8_pkg::CfgDstBase:    reg_dst_base   = data[rob8_pkg::BaseW-1:0];
      rob8_pkg::CfgDstStride:  reg_dst_stride = data[rob8_pkg::StrideW-1:0];
      rob8_pkg::CfgRectWidth:  reg_width      = data[rob8_pkg::CountW-1:0];
      rob8_pkg::CfgRectHeight: reg_height     = data[rob8_pkg::CountW-1:0];
      rob8_pkg::CfgReverse:    reg_reverse    = data[0];
      default:                 return;
    endcase
    rewind_walk();
  endfunction

  // Works out the write for one pixel item and steps the walk past it.
  function automatic pixel_write_t predict_write(rob8_pkg::pixel_t s, rob8_pkg::pixel_t d);
    pixel_write_t w;
    w.src_addr   = rob8_pkg::out_addr_t'(src_pos);
    w.write_addr = rob8_pkg::out_addr_t'(dst_pos);
    w.pixel      = rop_byte(reg_op, s, d);
    w.last       = (cols_to_go <= 1) && (rows_to_go <= 1);
    if (cols_to_go > 1) begin
      cols_to_go--;
      if (reg_reverse) begin
        src_pos = src_pos - 1'b1;
        dst_pos = dst_pos - 1'b1;
      end else begin
        src_pos = src_pos + 1'b1;
        dst_pos = dst_pos + 1'b1;
      end
    end else if (rows_to_go > 1) begin
      rows_to_go--;
      if (reg_reverse) begin
        src_line = src_line - walk_addr_t'(reg_src_stride);
        dst_line = dst_line - walk_addr_t'(reg_dst_stride);
      end else begin
        src_line = src_line + walk_addr_t'(reg_src_stride);
        dst_line = dst_line + walk_addr_t'(reg_dst_stride);
      end
      src_pos    = src_line;
      dst_pos    = dst_line;
      cols_to_go = at_least_one(reg_width);
    end else begin
      rewind_walk();
    end
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: one process sees the register port, both handshakes and the
  // watchdog, in that order, so the predictor never depends on process order.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    pixel_write_t want;
    bit           moved;
    if (!rst_ni) begin
      reset_model();
      expected_writes.delete();
      quiet_cycles = 0;
    end else begin
      moved = 1'b0;
      if (cfg_we_i) begin
        apply_cfg(cfg_index_i, cfg_wdata_i);
        moved = 1'b1;
      end
      if (in_valid_i && in_ready_o) begin
        expected_writes.push_back(predict_write(src_pixel_i, dst_pixel_i));
        moved = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        moved = 1'b1;
        if (expected_writes.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $error("unexpected result: src_addr %h write_addr %h result_pixel %h last %b",
                   src_addr_o, write_addr_o, result_pixel_o, last_o);
          end
        end else begin
          want = expected_writes.pop_front();
          if (src_addr_o !== want.src_addr) begin
            mismatches++;
            if (mismatches <= MaxReports) begin
              $error("src_addr: expected %h, actual %h", want.src_addr, src_addr_o);
            end
          end
          if (write_addr_o !== want.write_addr) begin
            mismatches++;
            if (mismatches <= MaxReports) begin
              $error("write_addr: expected %h, actual %h", want.write_addr, write_addr_o);
            end
          end
          if (result_pixel_o !== want.pixel) begin
            mismatches++;
            if (mismatches <= MaxReports) begin
              $error("result_pixel: expected %h, actual %h", want.pixel, result_pixel_o);
            end
          end
          if (last_o !== want.last) begin
            mismatches++;
            if (mismatches <= MaxReports) begin
              $error("last: expected %b, actual %b", want.last, last_o);
            end
          end
        end
      end
      // A healthy run never goes this long without some handshake completing.
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WatchdogCycles) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, a steady mode, and a long hold-off that a
  // test requests by bumping stall_token. The hold-off is counted here.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left  = stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (stall_token != stall_seen) begin
      stall_seen  = stall_token;
      stall_left  = StallCycles - 1;
      out_ready_i <= 1'b0;
    end else if (sink_steady) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= IdlePercent);
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. Every task starts and ends right after a rising edge.
  // ---------------------------------------------------------------------------

  // One register write, then the enable is lowered before the next one.
  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offers one pixel item and returns at the edge that accepts it. Valid is left
  // high so back-to-back items keep it up; a random idle gap lowers it first.
  task automatic send_pixel(input rob8_pkg::pixel_t s, input rob8_pkg::pixel_t d);
    int gap;
    gap = 0;
    if (!feed_steady) begin
      while ($urandom_range(0, 99) < IdlePercent) begin
        gap++;
      end
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    src_pixel_i <= s;
    dst_pixel_i <= d;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_random_pixels(input int n);
    repeat (n) begin
      send_pixel(rob8_pkg::pixel_t'($urandom), rob8_pkg::pixel_t'($urandom));
    end
  endtask

  // Stops offering items and waits until every expected write has come back,
  // plus the block's latency so nothing is left in flight before a register write.
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_writes.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  // Fills the bits above a register's width with noise half of the time; the
  // block must only look at the register's own bits.
  function automatic cfg_data_t with_noise(input int unsigned v, input int bits);
    cfg_data_t noise;
    noise = ($urandom_range(0, 1) == 0) ? '0 : cfg_data_t'($urandom);
    if (bits >= rob8_pkg::CfgDataW) begin
      return cfg_data_t'(v);
    end
    return (noise << bits) | (cfg_data_t'(v) & ((cfg_data_t'(1) << bits) - 1'b1));
  endfunction

  function automatic rob8_pkg::base_t rand_base();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      return rob8_pkg::base_t'($urandom_range(0, 15));
    end else if (pick < 50) begin
      return rob8_pkg::base_t'(24'hFFFFFF - $urandom_range(0, 15));
    end
    return rob8_pkg::base_t'($urandom);
  endfunction

  function automatic rob8_pkg::stride_t rand_stride();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      return '0;
    end else if (pick < 40) begin
      return '1;
    end
    return rob8_pkg::stride_t'($urandom);
  endfunction

  // Large and degenerate sizes for the rare big rectangles.
  function automatic int unsigned rand_big_count();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 4096;
      2:       return 8191;
      default: return $urandom_range(1, 8191);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Straight out of reset: a one-pixel copy at address zero.
  task automatic test_reset_state();
    send_pixel(8'h00, 8'hFF);
    wait_drain();
  endtask

  // Every logic operation on a byte pair that holds all four bit combinations.
  task automatic test_all_ops();
    rob8_pkg::logic_op_e op;
    op = op.first();
    repeat (op.num()) begin
      write_reg(rob8_pkg::CfgLogicOp, cfg_data_t'(op));
      send_pixel(8'hCC, 8'hAA);
      wait_drain();
      op = op.next();
    end
  endtask

  // A 2x2 walk whose source starts at the top of the address space and whose
  // strides are the largest allowed, so both pixel and row steps wrap.
  task automatic test_address_wrap();
    write_reg(rob8_pkg::CfgLogicOp, cfg_data_t'(rob8_pkg::OpXor));
    write_reg(rob8_pkg::CfgSrcBase, 24'hFFFFFF);
    write_reg(rob8_pkg::CfgDstBase, 24'h000000);
    write_reg(rob8_pkg::CfgSrcStride, cfg_data_t'(15'h7FFF));
    write_reg(rob8_pkg::CfgDstStride, cfg_data_t'(15'h7FFF));
    write_reg(rob8_pkg::CfgRectWidth, cfg_data_t'(2));
    write_reg(rob8_pkg::CfgRectHeight, cfg_data_t'(2));
    send_pixel(8'hFF, 8'h00);
    send_pixel(8'h00, 8'hFF);
    send_pixel(8'hFF, 8'hFF);
    send_pixel(8'h00, 8'h00);
    wait_drain();
  endtask

  // The same rectangle walked downward, so the destination wraps below zero.
  // Halfway through, a write to an unused index must leave the walk alone.
  task automatic test_reverse_walk();
    write_reg(rob8_pkg::CfgReverse, cfg_data_t'(1));
    write_reg(rob8_pkg::CfgLogicOp, cfg_data_t'(rob8_pkg::OpOnes));
    send_pixel(8'h00, 8'h00);
    send_pixel(8'h5A, 8'hA5);
    wait_drain();
    write_reg(IdxUnusedHi, 24'hFFFFFF);
    send_pixel(8'hFF, 8'hFF);
    send_pixel(8'h81, 8'h18);
    wait_drain();
    write_reg(rob8_pkg::CfgReverse, cfg_data_t'(0));
  endtask

  // Width and height of zero act as one; an all-ones width word keeps only the
  // 13-bit count, which is 8191.
  task automatic test_degenerate_sizes();
    write_reg(rob8_pkg::CfgLogicOp, cfg_data_t'(rob8_pkg::OpNand));
    write_reg(rob8_pkg::CfgRectWidth, cfg_data_t'(0));
    write_reg(rob8_pkg::CfgRectHeight, cfg_data_t'(0));
    send_pixel(8'hF0, 8'h0F);
    wait_drain();
    write_reg(rob8_pkg::CfgRectWidth, 24'hFFFFFF);
    write_reg(rob8_pkg::CfgRectHeight, cfg_data_t'(4096));
    send_random_pixels(3);
    wait_drain();
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // items, so the queue fills and the block must stall its input.
  task automatic test_backpressure();
    write_reg(rob8_pkg::CfgLogicOp, cfg_data_t'(rob8_pkg::OpOr));
    write_reg(rob8_pkg::CfgSrcBase, cfg_data_t'(rand_base()));
    write_reg(rob8_pkg::CfgDstBase, cfg_data_t'(rand_base()));
    write_reg(rob8_pkg::CfgRectWidth, cfg_data_t'(3));
    write_reg(rob8_pkg::CfgRectHeight, cfg_data_t'(4));
    stall_token <= stall_token + 1;
    feed_steady = 1'b1;
    send_random_pixels(40);
    feed_steady = 1'b0;
    wait_drain();
  endtask

  // Full rate on both sides: several rectangles back to back with no idling.
  task automatic test_streaming();
    write_reg(rob8_pkg::CfgLogicOp, cfg_data_t'(rob8_pkg::OpXnor));
    write_reg(rob8_pkg::CfgRectWidth, cfg_data_t'(5));
    write_reg(rob8_pkg::CfgRectHeight, cfg_data_t'(4));
    sink_steady <= 1'b1;
    feed_steady = 1'b1;
    send_random_pixels(100);
    feed_steady = 1'b0;
    sink_steady <= 1'b0;
    wait_drain();
  endtask

  // Random geometry and ops. Each phase programs the registers while the block
  // is idle, then walks one to three whole rectangles, sometimes stopping partway
  // so the next phase's writes restart a walk in progress. Big rectangles are
  // only ever walked a few pixels.
  task automatic test_random_rectangles();
    int unsigned sent;
    int unsigned w;
    int unsigned h;
    int unsigned span;
    int unsigned n;
    int unsigned pick;
    int unsigned split;
    sent = 0;
    while (sent < RandomItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        w = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
        h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 5);
      end else if (pick < 92) begin
        w = $urandom_range(9, 40);
        h = $urandom_range(1, 3);
      end else begin
        w = rand_big_count();
        h = rand_big_count();
      end

      if ($urandom_range(0, 99) < 70) begin
        write_reg(rob8_pkg::CfgLogicOp, with_noise($urandom_range(0, 15), 4));
      end
      if ($urandom_range(0, 99) < 70) begin
        write_reg(rob8_pkg::CfgSrcBase, cfg_data_t'(rand_base()));
      end
      if ($urandom_range(0, 99) < 70) begin
        write_reg(rob8_pkg::CfgSrcStride, with_noise(rand_stride(), rob8_pkg::StrideW));
      end
      if ($urandom_range(0, 99) < 70) begin
        write_reg(rob8_pkg::CfgDstBase, cfg_data_t'(rand_base()));
      end
      if ($urandom_range(0, 99) < 70) begin
        write_reg(rob8_pkg::CfgDstStride, with_noise(rand_stride(), rob8_pkg::StrideW));
      end
      if ($urandom_range(0, 99) < 70) begin
        write_reg(rob8_pkg::CfgReverse, with_noise($urandom_range(0, 1), 1));
      end
      write_reg(rob8_pkg::CfgRectWidth, with_noise(w, rob8_pkg::CountW));
      write_reg(rob8_pkg::CfgRectHeight, with_noise(h, rob8_pkg::CountW));
      if ($urandom_range(0, 99) < 15) begin
        write_reg(cfg_idx_t'($urandom_range(IdxUnusedLo, IdxUnusedHi)),
                  cfg_data_t'($urandom));
      end

      span = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
      if (span > 200) begin
        n = $urandom_range(1, 12);
      end else begin
        n = span * $urandom_range(1, 3);
        if ($urandom_range(0, 99) < 30) begin
          n += $urandom_range(1, span);
        end
      end
      // The last phase stops where the item budget runs out.
      if (n > RandomItems - sent) begin
        n = RandomItems - sent;
      end

      // Now and then pause mid-walk, poke an unused index, and carry on.
      if (n > 1 && $urandom_range(0, 99) < 15) begin
        split = $urandom_range(1, n - 1);
        send_random_pixels(split);
        wait_drain();
        write_reg(cfg_idx_t'($urandom_range(IdxUnusedLo, IdxUnusedHi)),
                  cfg_data_t'($urandom));
        send_random_pixels(n - split);
      end else begin
        send_random_pixels(n);
      end
      sent += n;
      wait_drain();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_all_ops();
    test_address_wrap();
    test_reverse_walk();
    test_degenerate_sizes();
    test_backpressure();
    test_streaming();
    test_random_rectangles();

    wait_drain();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
